FILE: hw/rtl/tct_pkg.sv
// Shared types and constants of the timed command table.
// Used by the table cell, the top level and the testbench.
package tct_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int RAW_FULL_SCALE  = 3900;
  localparam int PERCENT_MAX     = 100;
  localparam int THRESHOLD_RESET = 90;
  localparam int COUNT_W         = 5;
  localparam int PCT_W           = 7;
  localparam int RAW_W           = 12;
  localparam int TIME_W          = 32;
  localparam int PROD_W          = 20;

  typedef enum logic [1:0] {
    OP_DIRECT = 2'd0,
    OP_ADD    = 2'd1,
    OP_DEL    = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DEV_PUMP    = 2'd0,
    DEV_LIGHT   = 2'd1,
    DEV_VALVE   = 2'd2,
    DEV_UNKNOWN = 2'd3
  } dev_t;

  typedef struct packed {
    logic [1:0]        dev;
    logic              lvl;
    logic [TIME_W-1:0] due;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic               pump_on;
    logic               light_on;
    logic               valve_on;
    logic [COUNT_W-1:0] entry_count;
    logic               accepted;
    logic               table_full;
    logic [COUNT_W-1:0] fired_count;
  } res_t;

endpackage

FILE: hw/rtl/tct_cmd_if.sv
// Request channel carrying one command or tick to the table.
// Depends on nothing else.
interface tct_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [1:0]  device;
  logic        level;
  logic [31:0] due_time;
  logic [31:0] now_time;
  logic        time_valid;
  logic [11:0] water_sample;

  modport source (
    output valid, operation, device, level, due_time, now_time, time_valid, water_sample,
    input  ready
  );
  modport sink (
    input  valid, operation, device, level, due_time, now_time, time_valid, water_sample,
    output ready
  );
endinterface

FILE: hw/rtl/tct_res_if.sv
// Result channel carrying the output levels and status of one request.
// Depends on nothing else.
interface tct_res_if;
  logic       valid;
  logic       ready;
  logic       pump_on;
  logic       light_on;
  logic       valve_on;
  logic [4:0] entry_count;
  logic       accepted;
  logic       table_full;
  logic [4:0] fired_count;

  modport source (
    output valid, pump_on, light_on, valve_on, entry_count, accepted, table_full,
           fired_count,
    input  ready
  );
  modport sink (
    input  valid, pump_on, light_on, valve_on, entry_count, accepted, table_full,
           fired_count,
    output ready
  );
endinterface

FILE: hw/rtl/tct_cfg_if.sv
// Configuration write channel for the water threshold register.
// Depends on nothing else.
interface tct_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] water_full_percent;

  modport source (output valid, water_full_percent, input ready);
  modport sink (input valid, water_full_percent, output ready);
endinterface

FILE: hw/rtl/tct_cell.sv
// One slot of the schedule table: holds an entry, matches it against the key
// and takes its neighbour's entry when the table closes a gap. Uses tct_pkg.
module tct_cell (
  input  logic               clk,
  input  tct_pkg::cell_ctl_t ctl,
  input  tct_pkg::entry_t    key,
  input  tct_pkg::entry_t    nbr,
  input  logic               in_use,
  input  logic               match_in,
  output tct_pkg::entry_t    entry,
  output logic               match_out
);
  import tct_pkg::*;

  // A slot matches when it, or any slot before it, holds the key.
  assign match_out = match_in || (in_use && (entry == key));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      entry <= key;
    end else if (ctl.shift) begin
      entry <= nbr;
    end
  end

endmodule

FILE: hw/rtl/timed_command_table_top.sv
// Top level of the timed command table: control, output levels and the row
// of table cells. Uses tct_pkg, the three channel interfaces and tct_cell.
//
//   channel  modport  carries
//   cmd      sink     operation, device, level, due_time, now_time, ...
//   res      source   output levels, entry_count, accepted, table_full, ...
//   cfg      sink     water_full_percent
//
// A direct command, add or delete passes from S_IDLE through S_EXEC to S_EMIT.
// A tick passes through S_EXEC and S_SCAN to S_EMIT; when time_valid is set, S_SCAN walks the
// cell row from the last stored entry to the first, firing at most one entry a cycle.
// Reset empties the table, turns all outputs off and sets the threshold to 90.
// A new request is taken while a finished result still waits in the output.
module timed_command_table_top #(
  parameter int TABLE_DEPTH = tct_pkg::TABLE_DEPTH_DEF
) (
  input logic   clk,
  input logic   rst,
  tct_cmd_if.sink   cmd,
  tct_res_if.source res,
  tct_cfg_if.sink   cfg
);
  import tct_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t             state;
  op_t                op;
  entry_t             key;
  logic [TIME_W-1:0]  now;
  logic               tvalid;
  logic [RAW_W-1:0]   raw;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   ptr;
  logic [CNT_W-1:0]   fired;
  logic               acc;
  logic               full;
  logic               pump;
  logic               light;
  logic               valve;
  logic [PCT_W-1:0]   thr;
  res_t               res_r;
  logic               res_valid;

  entry_t             entries [TABLE_DEPTH];
  logic               match [TABLE_DEPTH];
  cell_ctl_t          ctl [TABLE_DEPTH];

  logic               exec;
  logic               any_match;
  logic               do_add;
  logic               do_del;
  logic [CNT_W-1:0]   ptr_m1;
  logic [IDX_W-1:0]   rd_idx;
  entry_t             cur;
  logic               due_hit;
  logic               drv_en;
  logic [1:0]         drv_dev;
  logic               drv_lvl;
  logic [PROD_W-1:0]  raw_scaled;
  logic [PROD_W-1:0]  thr_scaled;
  logic               pump_trip;

  generate
    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      entry_t nbr;
      logic   match_in;

      if (i == TABLE_DEPTH - 1) begin : g_last
        assign nbr = entries[i];
      end else begin : g_mid
        assign nbr = entries[i + 1];
      end

      if (i == 0) begin : g_first
        assign match_in = 1'b0;
      end else begin : g_rest
        assign match_in = match[i - 1];
      end

      assign ctl[i].load  = do_add && (count == CNT_W'(i));
      assign ctl[i].shift = (do_del && match[i]) || (due_hit && (IDX_W'(i) >= rd_idx));

      tct_cell u_cell (
        .clk       (clk),
        .ctl       (ctl[i]),
        .key       (key),
        .nbr       (nbr),
        .in_use    (CNT_W'(i) < count),
        .match_in  (match_in),
        .entry     (entries[i]),
        .match_out (match[i])
      );
    end
  endgenerate

  assign exec      = (state == S_EXEC);
  assign any_match = match[TABLE_DEPTH - 1];
  assign do_add    = exec && (op == OP_ADD) && !any_match && (count < CNT_W'(TABLE_DEPTH));
  assign do_del    = exec && (op == OP_DEL) && any_match;

  assign ptr_m1  = ptr - 1'b1;
  assign rd_idx  = ptr_m1[IDX_W-1:0];
  assign cur     = entries[rd_idx];
  assign due_hit = (state == S_SCAN) && (ptr != '0) && (cur.due <= now);

  assign drv_en  = (exec && (op == OP_DIRECT)) || due_hit;
  assign drv_dev = exec ? key.dev : cur.dev;
  assign drv_lvl = exec ? key.lvl : cur.lvl;

  // The clamped percent exceeds the threshold exactly when the threshold is
  // below full scale and raw * 100 reaches (threshold + 1) * 3900.
  assign raw_scaled = PROD_W'(raw) * PROD_W'(PERCENT_MAX);
  assign thr_scaled = (PROD_W'(thr) + 1'b1) * PROD_W'(RAW_FULL_SCALE);
  assign pump_trip  = (thr < PCT_W'(PERCENT_MAX)) && (raw_scaled >= thr_scaled);

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid       = res_valid;
  assign res.pump_on     = res_r.pump_on;
  assign res.light_on    = res_r.light_on;
  assign res.valve_on    = res_r.valve_on;
  assign res.entry_count = res_r.entry_count;
  assign res.accepted    = res_r.accepted;
  assign res.table_full  = res_r.table_full;
  assign res.fired_count = res_r.fired_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pump      <= 1'b0;
      light     <= 1'b0;
      valve     <= 1'b0;
      thr       <= PCT_W'(THRESHOLD_RESET);
      res_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        thr <= cfg.water_full_percent;
      end
      if (res_valid && res.ready && (state != S_EMIT)) begin
        res_valid <= 1'b0;
      end
      if (drv_en) begin
        unique case (drv_dev)
          DEV_PUMP:    pump  <= drv_lvl;
          DEV_LIGHT:   light <= drv_lvl;
          DEV_VALVE:   valve <= drv_lvl;
          DEV_UNKNOWN: ;
          default:     ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            op      <= op_t'(cmd.operation);
            key.dev <= cmd.device;
            key.lvl <= cmd.level;
            key.due <= cmd.due_time;
            now     <= cmd.now_time;
            tvalid  <= cmd.time_valid;
            raw     <= cmd.water_sample;
            state   <= S_EXEC;
          end
        end
        S_EXEC: begin
          acc   <= do_add || do_del;
          full  <= (op == OP_ADD) && !any_match && !do_add;
          fired <= '0;
          state <= (op == OP_TICK) ? S_SCAN : S_EMIT;
          unique case (op)
            OP_DIRECT: ;
            OP_ADD: begin
              if (do_add) begin
                count <= count + 1'b1;
              end
            end
            OP_DEL: begin
              if (do_del) begin
                count <= count - 1'b1;
              end
            end
            OP_TICK: begin
              if (pump_trip) begin
                pump <= 1'b0;
              end
              ptr <= tvalid ? count : '0;
            end
            default: ;
          endcase
        end
        S_SCAN: begin
          if (ptr == '0) begin
            state <= S_EMIT;
          end else begin
            ptr <= ptr_m1;
            if (due_hit) begin
              count <= count - 1'b1;
              fired <= fired + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (!res_valid || res.ready) begin
            res_r.pump_on     <= pump;
            res_r.light_on    <= light;
            res_r.valve_on    <= valve;
            res_r.entry_count <= COUNT_W'(count);
            res_r.accepted    <= acc;
            res_r.table_full  <= full;
            res_r.fired_count <= COUNT_W'(fired);
            res_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: tb/sv/timed_command_table_top_test.sv
`timescale 1ns / 100ps
// Self-checking test of timed_command_table_top: directed and random requests, a
// predictor of the command table, and random stalls on both channels.
// Depends on tct_pkg and the tct_cmd_if, tct_res_if and tct_cfg_if interfaces.
module timed_command_table_top_test;
  import tct_pkg::*;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 164;

  typedef struct packed {
    op_t         op;
    dev_t        dev;
    logic        lvl;
    logic [31:0] due;
    logic [31:0] now;
    logic        tv;
    logic [11:0] raw;
  } request_t;

  typedef struct packed {
    request_t req;
    logic     has_want;
    res_t     want;
  } directed_row_t;

  localparam directed_row_t STIM_TABLE [22] = '{
    '{'{OP_TICK,   DEV_PUMP,    1'b0, 32'd0, 32'd0, 1'b0, 12'd0},
      1'b1, '{1'b0, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0, 5'd0}},
    '{'{OP_DIRECT, DEV_PUMP,    1'b1, 32'd0, 32'd0, 1'b0, 12'd0},
      1'b1, '{1'b1, 1'b0, 1'b0, 5'd0, 1'b0, 1'b0, 5'd0}},
    '{'{OP_DIRECT, DEV_LIGHT,   1'b1, 32'd0, 32'd0, 1'b0, 12'd0},
      1'b1, '{1'b1, 1'b1, 1'b0, 5'd0, 1'b0, 1'b0, 5'd0}},
    '{'{OP_DIRECT, DEV_VALVE,   1'b1, 32'd0, 32'd0, 1'b0, 12'd0},
      1'b1, '{1'b1, 1'b1, 1'b1, 5'd0, 1'b0, 1'b0, 5'd0}},
    '{'{OP_DIRECT, DEV_UNKNOWN, 1'b0, 32'd0, 32'd0, 1'b0, 12'd0},
      1'b1, '{1'b1, 1'b1, 1'b1, 5'd0, 1'b0, 1'b0, 5'd0}},
    '{'{OP_TICK,   DEV_PUMP,    1'b0, 32'd0, 32'd0, 1'b0, 12'd4095},
      1'b1, '{1'b0, 1'b1, 1'b1, 5'd0, 1'b0, 1'b0, 5'd0}},
    '{'{OP_DIRECT, DEV_PUMP,    1'b1, 32'd0, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_TICK,   DEV_PUMP,    1'b0, 32'd0, 32'd0, 1'b1, 12'd3548}, 1'b0, '0},
    '{'{OP_TICK,   DEV_PUMP,    1'b0, 32'd0, 32'd0, 1'b0, 12'd3549}, 1'b0, '0},
    '{'{OP_ADD,    DEV_PUMP,    1'b1, 32'd0, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_ADD,    DEV_PUMP,    1'b1, 32'd0, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_ADD,    DEV_UNKNOWN, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_ADD,    DEV_LIGHT,   1'b0, 32'd100, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_DEL,    DEV_LIGHT,   1'b0, 32'd101, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_DEL,    DEV_UNKNOWN, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_ADD,    DEV_VALVE,   1'b0, 32'd50, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_TICK,   DEV_PUMP,    1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_TICK,   DEV_PUMP,    1'b0, 32'd0, 32'd50, 1'b1, 12'd0}, 1'b0, '0},
    '{'{OP_ADD,    DEV_UNKNOWN, 1'b1, 32'd7, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_TICK,   DEV_PUMP,    1'b0, 32'd0, 32'hFFFF_FFFF, 1'b1, 12'd4095}, 1'b0, '0},
    '{'{OP_DIRECT, DEV_LIGHT,   1'b0, 32'd0, 32'd0, 1'b0, 12'd0}, 1'b0, '0},
    '{'{OP_DIRECT, DEV_VALVE,   1'b0, 32'd0, 32'd0, 1'b0, 12'd0}, 1'b0, '0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  tct_cmd_if cmd_ch ();
  tct_res_if res_ch ();
  tct_cfg_if cfg_ch ();

  timed_command_table_top dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  entry_t      sched_rows [DEPTH];
  int unsigned rows_used;
  logic        pump_q, light_q, valve_q;
  logic [6:0]  threshold_q;

  res_t        pending [$];
  logic [31:0] base_time;
  bit          steady;
  int          sink_hold;
  int          idle_cycles;
  int          error_count;
  int          requests_sent, results_checked, thresholds_written;
  int          full_refusals, entries_fired;

  always #5 clk = ~clk;

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      flag_error($sformatf("result %0d: %s is %0d, expected %0d", results_checked, name,
                           got, want));
  endtask

  function automatic void drive_output(logic [1:0] dev, logic lvl);
    case (dev)
      DEV_PUMP:  pump_q = lvl;
      DEV_LIGHT: light_q = lvl;
      DEV_VALVE: valve_q = lvl;
      default: ;
    endcase
  endfunction

  function automatic void drop_row(int idx);
    for (int k = idx; k + 1 < rows_used; k++) sched_rows[k] = sched_rows[k + 1];
    rows_used--;
  endfunction

  function automatic res_t apply_request(request_t rq);
    res_t        r;
    int          idx;
    int          i;
    int unsigned pct;
    r   = '0;
    idx = -1;
    for (int k = rows_used - 1; k >= 0; k--)
      if (sched_rows[k].dev == rq.dev && sched_rows[k].lvl == rq.lvl &&
          sched_rows[k].due == rq.due)
        idx = k;
    case (rq.op)
      OP_DIRECT: drive_output(rq.dev, rq.lvl);
      OP_ADD: begin
        if (idx < 0) begin
          if (rows_used >= DEPTH) begin
            r.table_full = 1'b1;
          end else begin
            sched_rows[rows_used] = '{dev: rq.dev, lvl: rq.lvl, due: rq.due};
            rows_used++;
            r.accepted = 1'b1;
          end
        end
      end
      OP_DEL: begin
        if (idx >= 0) begin
          drop_row(idx);
          r.accepted = 1'b1;
        end
      end
      default: begin
        pct = int'(rq.raw) * PERCENT_MAX / RAW_FULL_SCALE;
        if (pct > PERCENT_MAX) pct = PERCENT_MAX;
        if (pct > threshold_q) pump_q = 1'b0;
        if (rq.tv) begin
          i = rows_used;
          while (i > 0) begin
            i--;
            if (sched_rows[i].due <= rq.now) begin
              drive_output(sched_rows[i].dev, sched_rows[i].lvl);
              drop_row(i);
              r.fired_count++;
            end
          end
        end
      end
    endcase
    r.pump_on     = pump_q;
    r.light_on    = light_q;
    r.valve_on    = valve_q;
    r.entry_count = rows_used[4:0];
    return r;
  endfunction

  function automatic request_t random_request();
    request_t rq;
    rq.op  = op_t'($urandom_range(0, 3));
    rq.dev = dev_t'($urandom_range(0, 3));
    rq.lvl = 1'($urandom_range(0, 1));
    rq.due = $urandom();
    rq.now = $urandom();
    rq.tv  = 1'($urandom_range(0, 1));
    rq.raw = 12'($urandom_range(0, 4095));
    return rq;
  endfunction

  task automatic push_request(request_t rq, logic has_want, res_t want);
    int   gap;
    res_t got;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.operation    <= rq.op;
    cmd_ch.device       <= rq.dev;
    cmd_ch.level        <= rq.lvl;
    cmd_ch.due_time     <= rq.due;
    cmd_ch.now_time     <= rq.now;
    cmd_ch.time_valid   <= rq.tv;
    cmd_ch.water_sample <= rq.raw;
    do @(posedge clk); while (!cmd_ch.ready);
    got = apply_request(rq);
    pending.insert(pending.size(), has_want ? want : got);
    requests_sent++;
    full_refusals += int'(got.table_full);
    entries_fired += int'(got.fired_count);
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(logic [6:0] pct);
    drain_results();
    cfg_ch.valid              <= 1'b1;
    cfg_ch.water_full_percent <= pct;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    threshold_q = pct;
    thresholds_written++;
  endtask

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst) begin
      sink_hold = 0;
      res_ch.ready <= 1'b1;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending.size() == 0) begin
          flag_error("result arrived with no request outstanding");
        end else begin
          want = pending.pop_front();
          check_field("pump_on", 32'(res_ch.pump_on), 32'(want.pump_on));
          check_field("light_on", 32'(res_ch.light_on), 32'(want.light_on));
          check_field("valve_on", 32'(res_ch.valve_on), 32'(want.valve_on));
          check_field("entry_count", 32'(res_ch.entry_count), 32'(want.entry_count));
          check_field("accepted", 32'(res_ch.accepted), 32'(want.accepted));
          check_field("table_full", 32'(res_ch.table_full), 32'(want.table_full));
          check_field("fired_count", 32'(res_ch.fired_count), 32'(want.fired_count));
          results_checked++;
        end
        sink_hold = steady ? 0 : $urandom_range(0, 16);
        if (sink_hold != 0) res_ch.ready <= 1'b0;
      end else if (sink_hold != 0) begin
        sink_hold--;
        if (sink_hold == 0) res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no handshake for %0d cycles", STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end else begin
      idle_cycles = 0;
    end
  end

  initial begin
    request_t    rq;
    int          roll, pick, slot;
    int          thresh_plan [PHASES];
    thresh_plan = '{0, 100, -1, 1, 99, -1, 90, 50};
    rows_used   = 0;
    pump_q      = 1'b0;
    light_q     = 1'b0;
    valve_q     = 1'b0;
    threshold_q = 7'(THRESHOLD_RESET);
    steady      = 1'b0;
    cmd_ch.valid              <= 1'b0;
    cmd_ch.operation          <= OP_DIRECT;
    cmd_ch.device             <= DEV_PUMP;
    cmd_ch.level              <= 1'b0;
    cmd_ch.due_time           <= '0;
    cmd_ch.now_time           <= '0;
    cmd_ch.time_valid         <= 1'b0;
    cmd_ch.water_sample       <= '0;
    cfg_ch.valid              <= 1'b0;
    cfg_ch.water_full_percent <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (STIM_TABLE[n])
      push_request(STIM_TABLE[n].req, STIM_TABLE[n].has_want, STIM_TABLE[n].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      set_threshold(thresh_plan[ph] < 0 ? 7'($urandom_range(0, 100)) : 7'(thresh_plan[ph]));
      if (ph == 1) base_time = 32'd0;
      else if (ph == 4) base_time = 32'hFFFF_FF70;
      else base_time = $urandom_range(0, 32'hFFFF_FE00);

      if (ph == 0) begin
        while (rows_used < DEPTH) begin
          rq    = random_request();
          rq.op = OP_ADD;
          push_request(rq, 1'b0, '0);
        end
        rq    = random_request();
        rq.op = OP_ADD;
        push_request(rq, 1'b0, '0);
        slot   = $urandom_range(0, DEPTH - 1);
        rq.dev = dev_t'(sched_rows[slot].dev);
        rq.lvl = sched_rows[slot].lvl;
        rq.due = sched_rows[slot].due;
        push_request(rq, 1'b0, '0);
        rq     = random_request();
        rq.op  = OP_TICK;
        rq.tv  = 1'b1;
        rq.now = 32'hFFFF_FFFF;
        push_request(rq, 1'b0, '0);
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        if (k == PHASE_ITEMS / 2) drain_results();
        rq   = random_request();
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 9);
        rq.op = roll < 15 ? OP_DIRECT : roll < 52 ? OP_ADD : roll < 70 ? OP_DEL : OP_TICK;
        case (rq.op)
          OP_ADD, OP_DEL: begin
            if (rows_used != 0 && pick < (rq.op == OP_DEL ? 7 : 2)) begin
              slot   = $urandom_range(0, rows_used - 1);
              rq.dev = dev_t'(sched_rows[slot].dev);
              rq.lvl = sched_rows[slot].lvl;
              rq.due = sched_rows[slot].due;
            end else if (pick < 8) begin
              rq.due = base_time + 8 * $urandom_range(0, 15);
            end else if (pick == 8) begin
              rq.due = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            end
          end
          OP_TICK: begin
            rq.tv = ($urandom_range(0, 9) != 0);
            if (pick < 8) rq.now = base_time + $urandom_range(0, 140);
            else if (pick == 8) rq.now = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            if ($urandom_range(0, 1)) rq.raw = 12'(threshold_q * 39 + $urandom_range(0, 78));
          end
          default: ;
        endcase
        push_request(rq, 1'b0, '0);
      end
    end

    steady = 1'b0;
    drain_results();
    repeat (24) @(posedge clk);
    if (pending.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending.size()));
    $display("Covered %0d requests and %0d results over %0d threshold settings.",
             requests_sent, results_checked, thresholds_written);
    $display("Adds refused on a full table: %0d; scheduled entries fired by ticks: %0d.",
             full_refusals, entries_fired);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
